### hw/rtl/nbc_pkg.sv
// ----------------------------------------------------------------------------
// nbc_pkg
// Shared types and constants of the discrete naive Bayes classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package nbc_pkg;

    localparam int Q_FRAC   = 16;
    localparam int Q_W      = Q_FRAC + 1;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_FRAC;

    localparam int DIV_STEP = 4;
    localparam int DIV_ITER = Q_FRAC / DIV_STEP;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDECIDED    = 2'd3;

    typedef enum logic [1:0] {
        REQ_TRAIN    = 2'd0,
        REQ_CLASSIFY = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

endpackage

`default_nettype wire

### hw/rtl/nbc_count_ram.sv
// ----------------------------------------------------------------------------
// nbc_count_ram
// Single-port-write, single-port-read count memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc_count_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/nbc_div.sv
// ----------------------------------------------------------------------------
// nbc_div
// Iterative likelihood divider: count * 2^16 / total, saturated to one, zero for a zero total.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc_div #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [COUNT_WIDTH-1:0] count,
    input  wire logic [COUNT_WIDTH-1:0] total,
    output logic                        done,
    output logic [nbc_pkg::Q_W-1:0]     factor
);
    import nbc_pkg::*;

    localparam int CNT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] den_reg;
    logic [Q_FRAC-1:0]      quo_reg;
    logic [Q_W-1:0]         factor_reg;

    logic [COUNT_WIDTH-1:0] rem_next;
    logic [Q_FRAC-1:0]      quo_next;

    always_comb begin
        logic [COUNT_WIDTH:0] shifted;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            shifted  = {rem_next, 1'b0};
            quo_next = {quo_next[Q_FRAC-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg}) begin
                shifted     = shifted - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = shifted[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (total == '0) begin
                    factor_reg <= '0;
                    done_reg   <= 1'b1;
                end else if (count >= total) begin
                    factor_reg <= Q_ONE;
                    done_reg   <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= count;
                    den_reg  <= total;
                    quo_reg  <= '0;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_ITER - 1)) begin
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                    factor_reg <= {1'b0, quo_next};
                end
            end
        end
    end

    assign done   = done_reg;
    assign factor = factor_reg;

endmodule

`default_nettype wire

### hw/rtl/naive_bayes_classifier_top.sv
// ----------------------------------------------------------------------------
// naive_bayes_classifier_top
// Discrete naive Bayes engine: trains per-bucket counts, classifies samples.
// ----------------------------------------------------------------------------
// One item at a time. A train item reads its count and writes it back.
// A classify item with a feature in range does, for each class in use,
// one count memory read, the likelihood division at 4 quotient bits a
// cycle, and one multiply into the running product; the last item of a
// sample adds a winner scan over the classes in use and then loads the
// result register once the output is free. After reset and after a clear
// item the count memory is swept one entry a cycle, during which no item
// is taken.
`default_nettype none

module naive_bayes_classifier_top #(
    parameter int NUM_CLASSES  = 8,
    parameter int NUM_FEATURES = 64,
    parameter int MAX_BUCKETS  = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nbc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [nbc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [2:0]                    s_class_id,
    input  wire logic [5:0]                    s_feature_index,
    input  wire logic [3:0]                    s_feature_bucket,
    input  wire logic                          s_last_element,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_predicted_class,
    output logic [16:0]                        m_best_score,
    output logic [16:0]                        m_second_score
);
    import nbc_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * NUM_FEATURES * MAX_BUCKETS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int NC_W   = $clog2(NUM_CLASSES + 1);
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_TR_RD,
        ST_TR_WR,
        ST_CL_RD,
        ST_CL_DIV,
        ST_CL_WAIT,
        ST_CL_MUL,
        ST_WIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [4:0]  bucket_count_reg;
    logic [3:0]  class_count_reg;
    logic [16:0] margin_reg;
    logic [7:0]  undecided_reg;

    logic [CLS_W-1:0]       cls_reg;
    logic [5:0]             feat_reg;
    logic [BKT_W-1:0]       bkt_reg;
    logic                   last_reg;
    logic                   feat_ok_reg;
    logic [CLS_W-1:0]       j_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [COUNT_WIDTH-1:0] totals_reg [NUM_CLASSES];
    logic [Q_W-1:0]         prod_reg [NUM_CLASSES];
    logic [2*Q_W-1:0]       mul_reg;
    logic [Q_W-1:0]         best_reg;
    logic [Q_W-1:0]         second_reg;
    logic [CLS_W-1:0]       winner_reg;

    logic                   m_valid_reg;
    logic [7:0]             m_class_reg;
    logic [16:0]            m_best_reg;
    logic [16:0]            m_second_reg;

    logic [NC_W-1:0]        nc;
    logic [NB_W-1:0]        nb;
    logic [CLS_W-1:0]       nc_last;
    logic [BKT_W-1:0]       bkt_in;
    logic                   accept;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   div_start;
    logic                   div_done;
    logic [Q_W-1:0]         div_factor;
    logic [ADDR_W-1:0]      tr_addr;
    logic [ADDR_W-1:0]      cl_addr;
    logic                   out_free;

    function automatic logic [ADDR_W-1:0] slot(input logic [CLS_W-1:0] c,
                                               input logic [5:0] f,
                                               input logic [BKT_W-1:0] b);
        return ADDR_W'((32'(c) * NUM_FEATURES + 32'(f)) * MAX_BUCKETS + 32'(b));
    endfunction

    always_comb begin
        if (bucket_count_reg == '0) begin
            nb = NB_W'(1);
        end else if (32'(bucket_count_reg) > MAX_BUCKETS) begin
            nb = NB_W'(MAX_BUCKETS);
        end else begin
            nb = NB_W'(32'(bucket_count_reg));
        end
        if (class_count_reg == '0) begin
            nc = NC_W'(1);
        end else if (32'(class_count_reg) > NUM_CLASSES) begin
            nc = NC_W'(NUM_CLASSES);
        end else begin
            nc = NC_W'(32'(class_count_reg));
        end
        nc_last = CLS_W'(nc - 1'b1);
        if (32'(s_feature_bucket) >= 32'(nb)) begin
            bkt_in = BKT_W'(nb - 1'b1);
        end else begin
            bkt_in = BKT_W'(32'(s_feature_bucket));
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign tr_addr = slot(cls_reg, feat_reg, bkt_reg);
    assign cl_addr = slot(j_reg, feat_reg, bkt_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tr_addr;
        wr_en   = 1'b0;
        wr_addr = tr_addr;
        wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
        case (state_reg)
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            ST_TR_RD: begin
                rd_en = 1'b1;
            end
            ST_TR_WR: begin
                wr_en = feat_ok_reg;
            end
            ST_CL_RD: begin
                rd_en   = 1'b1;
                rd_addr = cl_addr;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_CL_DIV);

    nbc_count_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    nbc_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .count   (rd_data),
        .total   (totals_reg[j_reg]),
        .done    (div_done),
        .factor  (div_factor)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= 5'd5;
            class_count_reg  <= 4'd2;
            margin_reg       <= '0;
            undecided_reg    <= 8'd255;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_wr_data[4:0];
                CFG_CLASS_COUNT:  class_count_reg  <= cfg_wr_data[3:0];
                CFG_MARGIN:       margin_reg       <= cfg_wr_data[16:0];
                CFG_UNDECIDED:    undecided_reg    <= cfg_wr_data[7:0];
                default:          margin_reg       <= margin_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
            j_reg        <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                totals_reg[i] <= '0;
                prod_reg[i]   <= Q_ONE;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cls_reg     <= CLS_W'(s_class_id);
                        feat_reg    <= s_feature_index;
                        bkt_reg     <= bkt_in;
                        last_reg    <= s_last_element;
                        feat_ok_reg <= (32'(s_feature_index) < NUM_FEATURES);
                        j_reg       <= '0;
                        best_reg    <= '0;
                        second_reg  <= '0;
                        winner_reg  <= '0;
                        case (req_t'(s_req_type))
                            REQ_TRAIN: begin
                                if (32'(s_class_id) < 32'(nc)) begin
                                    state_reg <= ST_TR_RD;
                                end
                            end
                            REQ_CLASSIFY: begin
                                if (32'(s_feature_index) < NUM_FEATURES) begin
                                    state_reg <= ST_CL_RD;
                                end else if (s_last_element) begin
                                    state_reg <= ST_WIN;
                                end
                            end
                            REQ_CLEAR: begin
                                clr_addr_reg <= '0;
                                state_reg    <= ST_CLR;
                                for (int i = 0; i < NUM_CLASSES; i++) begin
                                    totals_reg[i] <= '0;
                                    prod_reg[i]   <= Q_ONE;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CLR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TR_RD: begin
                    state_reg <= ST_TR_WR;
                end
                ST_TR_WR: begin
                    if (last_reg && totals_reg[cls_reg] != COUNT_MAX) begin
                        totals_reg[cls_reg] <= totals_reg[cls_reg] + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_CL_RD: begin
                    state_reg <= ST_CL_DIV;
                end
                ST_CL_DIV: begin
                    state_reg <= ST_CL_WAIT;
                end
                ST_CL_WAIT: begin
                    if (div_done) begin
                        mul_reg   <= prod_reg[j_reg] * div_factor;
                        state_reg <= ST_CL_MUL;
                    end
                end
                ST_CL_MUL: begin
                    prod_reg[j_reg] <= mul_reg[Q_FRAC +: Q_W];
                    if (j_reg == nc_last) begin
                        j_reg     <= '0;
                        state_reg <= last_reg ? ST_WIN : ST_IDLE;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_CL_RD;
                    end
                end
                ST_WIN: begin
                    if (prod_reg[j_reg] > best_reg) begin
                        second_reg <= best_reg;
                        best_reg   <= prod_reg[j_reg];
                        winner_reg <= j_reg;
                    end
                    if (j_reg == nc_last) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_best_reg   <= best_reg;
                        m_second_reg <= second_reg;
                        if ({1'b0, best_reg} >= {1'b0, second_reg} + {1'b0, margin_reg}) begin
                            m_class_reg <= 8'(winner_reg);
                        end else begin
                            m_class_reg <= undecided_reg;
                        end
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                            prod_reg[i] <= Q_ONE;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_class = m_class_reg;
    assign m_best_score      = m_best_reg;
    assign m_second_score    = m_second_reg;

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the discrete naive Bayes classifier. Train,
// classify, clear and no-op items are sent through the item channel under
// several register settings and idle and stall patterns; a bit-accurate
// predictor of the count tables and running products works out each
// result, which is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import nbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS = 8;
    localparam int NFEAT = 64;
    localparam int NBKT = 16;
    localparam int CNT_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        req_t       req;
        logic [2:0] cls;
        logic [5:0] feat;
        logic [3:0] bkt;
        logic       last;
    } sample_item_t;

    typedef struct packed {
        logic [7:0]  cls;
        logic [16:0] best;
        logic [16:0] second;
    } verdict_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type = '0;
    logic [2:0]           s_class_id = '0;
    logic [5:0]           s_feature_index = '0;
    logic [3:0]           s_feature_bucket = '0;
    logic                 s_last_element = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_predicted_class;
    logic [16:0]          m_best_score;
    logic [16:0]          m_second_score;

    naive_bayes_classifier_top u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] cnt_mem [NCLS*NFEAT*NBKT];
    logic [15:0] cls_total [NCLS];
    logic [16:0] run_prod [NCLS];
    logic [4:0]  r_buckets = 5;
    logic [3:0]  r_classes = 2;
    logic [16:0] r_margin = 0;
    logic [7:0]  r_undecided = 8'd255;

    sample_item_t pend_items[$];
    verdict_t     verdicts_due[$];
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;
    bit           took = 0;

    function automatic int eff_buckets();
        if (r_buckets == 0) return 1;
        if (r_buckets > NBKT) return NBKT;
        return r_buckets;
    endfunction

    function automatic int eff_classes();
        if (r_classes == 0) return 1;
        if (r_classes > NCLS) return NCLS;
        return r_classes;
    endfunction

    function automatic void wipe_tables();
        foreach (cnt_mem[i]) cnt_mem[i] = '0;
        foreach (cls_total[i]) cls_total[i] = '0;
        foreach (run_prod[i]) run_prod[i] = Q_ONE;
    endfunction

    function automatic void bayes_update(sample_item_t it);
        int nb, nc, b, k;
        logic [63:0] factor, prod;
        logic [16:0] best, second;
        logic [7:0] win;
        verdict_t v;
        nb = eff_buckets();
        nc = eff_classes();
        b = (it.bkt >= nb) ? nb - 1 : int'(it.bkt);
        case (it.req)
            REQ_CLEAR: wipe_tables();
            REQ_TRAIN: begin
                if (it.cls < nc) begin
                    k = (int'(it.cls) * NFEAT + int'(it.feat)) * NBKT + b;
                    if (cnt_mem[k] < CNT_MAX) cnt_mem[k] = cnt_mem[k] + 16'd1;
                    if (it.last && cls_total[it.cls] < CNT_MAX)
                        cls_total[it.cls] = cls_total[it.cls] + 16'd1;
                end
            end
            REQ_CLASSIFY: begin
                for (int j = 0; j < nc; j++) begin
                    factor = 0;
                    if (cls_total[j] != 0) begin
                        k = (j * NFEAT + int'(it.feat)) * NBKT + b;
                        factor = (64'(cnt_mem[k]) << 16) / 64'(cls_total[j]);
                        if (factor > Q_ONE) factor = Q_ONE;
                    end
                    prod = (64'(run_prod[j]) * factor) >> 16;
                    run_prod[j] = prod[16:0];
                end
                if (it.last) begin
                    best = 0;
                    second = 0;
                    win = 0;
                    for (int j = 0; j < nc; j++) begin
                        if (run_prod[j] > best) begin
                            second = best;
                            best = run_prod[j];
                            win = j[7:0];
                        end
                    end
                    v.cls = (18'(best) >= 18'(second) + 18'(r_margin)) ? win : r_undecided;
                    v.best = best;
                    v.second = second;
                    verdicts_due = {verdicts_due, v};
                    foreach (run_prod[i]) run_prod[i] = Q_ONE;
                end
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        sample_item_t it;
        if (s_valid && !took) begin
        end else if (pend_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            it = pend_items.pop_front();
            s_valid <= 1'b1;
            s_req_type <= it.req;
            s_class_id <= it.cls;
            s_feature_index <= it.feat;
            s_feature_bucket <= it.bkt;
            s_last_element <= it.last;
        end else begin
            s_valid <= 1'b0;
        end
        took = 0;
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        sample_item_t it;
        verdict_t v;
        bit moved;
        if (aresetn) begin
            moved = 0;
            if (s_valid && s_ready) begin
                it.req = req_t'(s_req_type);
                it.cls = s_class_id;
                it.feat = s_feature_index;
                it.bkt = s_feature_bucket;
                it.last = s_last_element;
                bayes_update(it);
                took = 1;
                moved = 1;
            end
            if (m_valid && m_ready) begin
                moved = 1;
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result cls=%0d best=%0d second=%0d", $time,
                             m_predicted_class, m_best_score, m_second_score);
                    errors++;
                end else begin
                    v = verdicts_due.pop_front();
                    if (m_predicted_class !== v.cls) begin
                        $display("%0t: predicted_class exp %0d got %0d", $time, v.cls,
                                 m_predicted_class);
                        errors++;
                    end
                    if (m_best_score !== v.best) begin
                        $display("%0t: best_score exp %0d got %0d", $time, v.best,
                                 m_best_score);
                        errors++;
                    end
                    if (m_second_score !== v.second) begin
                        $display("%0t: second_score exp %0d got %0d", $time, v.second,
                                 m_second_score);
                        errors++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL naive_bayes_classifier_top");
                $finish;
            end
        end
    end

    function automatic void add_item(req_t r, int c, int f, int b, bit l);
        sample_item_t it;
        it.req = r;
        it.cls = c[2:0];
        it.feat = f[5:0];
        it.bkt = b[3:0];
        it.last = l;
        pend_items = {pend_items, it};
    endfunction

    // a sample of n elements of one random class, with feature indexes from 0 to fspan
    function automatic void add_sample(req_t r, int n, int fspan);
        int c;
        c = $urandom_range(7);
        for (int i = 0; i < n; i++)
            add_item(r, c, $urandom_range(fspan), $urandom_range(15), i == n - 1);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val[CFG_W-1:0];
        case (idx)
            CFG_BUCKET_COUNT: r_buckets = val[4:0];
            CFG_CLASS_COUNT:  r_classes = val[3:0];
            CFG_MARGIN:       r_margin = val[16:0];
            default:          r_undecided = val[7:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pend_items.size() > 0 || s_valid || verdicts_due.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    initial begin
        int nitems, fspan;
        wipe_tables();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        add_item(REQ_CLASSIFY, 0, 0, 0, 1);
        add_item(REQ_TRAIN, 0, 0, 0, 1);
        add_item(REQ_TRAIN, 1, 0, 15, 1);
        add_item(REQ_TRAIN, 7, 0, 0, 1);
        add_item(REQ_NONE, 5, 63, 15, 1);
        add_item(REQ_TRAIN, 1, 63, 4, 0);
        add_item(REQ_TRAIN, 1, 63, 4, 1);
        add_item(REQ_CLASSIFY, 3, 0, 0, 1);
        add_item(REQ_CLASSIFY, 0, 0, 9, 1);
        add_item(REQ_CLASSIFY, 0, 63, 4, 0);
        add_item(REQ_CLASSIFY, 0, 0, 15, 1);
        add_item(REQ_CLEAR, 0, 0, 0, 0);
        add_item(REQ_CLASSIFY, 0, 0, 0, 1);
        add_item(REQ_TRAIN, 0, 42, 2, 1);
        add_item(REQ_CLASSIFY, 0, 42, 2, 1);
        drain();

        write_reg(CFG_BUCKET_COUNT, 16);
        write_reg(CFG_CLASS_COUNT, 8);
        write_reg(CFG_MARGIN, 65536);
        write_reg(CFG_UNDECIDED, 8'h55);
        add_item(REQ_TRAIN, 7, 1, 15, 1);
        add_item(REQ_CLASSIFY, 0, 1, 15, 1);
        add_item(REQ_CLASSIFY, 0, 2, 0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            case (ph)
                0: begin
                    write_reg(CFG_BUCKET_COUNT, 0);
                    write_reg(CFG_CLASS_COUNT, 0);
                    write_reg(CFG_MARGIN, 0);
                    write_reg(CFG_UNDECIDED, 0);
                end
                1: begin
                    write_reg(CFG_BUCKET_COUNT, 31);
                    write_reg(CFG_CLASS_COUNT, 15);
                    write_reg(CFG_MARGIN, 65536);
                    write_reg(CFG_UNDECIDED, 255);
                end
                default: begin
                    write_reg(CFG_BUCKET_COUNT, $urandom_range(31));
                    write_reg(CFG_CLASS_COUNT, $urandom_range(15));
                    write_reg(CFG_MARGIN, ($urandom_range(3) == 0) ? $urandom_range(65536)
                                                                   : $urandom_range(2000));
                    write_reg(CFG_UNDECIDED, $urandom_range(255));
                end
            endcase
            fspan = (ph % 3 == 2) ? 63 : 3;
            if (ph == 5) add_item(REQ_CLEAR, 0, 0, 0, 0);
            nitems = 0;
            while (nitems < 120) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        add_sample(REQ_TRAIN, $urandom_range(1, 4), fspan);
                        nitems += 2;
                    end
                    4, 5, 6, 7: begin
                        add_sample(REQ_CLASSIFY, $urandom_range(1, 4), fspan);
                        nitems += 2;
                    end
                    8: begin
                        add_item(REQ_NONE, $urandom_range(7), $urandom_range(63),
                                 $urandom_range(15), $urandom_range(1));
                    end
                    default: begin
                        add_item(req_t'($urandom_range(1)), $urandom_range(7),
                                 $urandom_range(63), $urandom_range(15), $urandom_range(1));
                        nitems++;
                    end
                endcase
            end
            add_item(REQ_CLASSIFY, 0, $urandom_range(fspan), $urandom_range(15), 1);
            drain();
        end

        if (errors == 0) begin
            $display("PASS naive_bayes_classifier_top");
        end else begin
            $display("FAIL naive_bayes_classifier_top");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/nbc_pkg.sv
hw/rtl/nbc_count_ram.sv
hw/rtl/nbc_div.sv
hw/rtl/naive_bayes_classifier_top.sv
test/tb_top.sv
